// ===== rtl/core/lfps_pkg.sv =====
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types, widths and calibration tables for the line-follow PD
// steering block.
// ----------------------------------------------------------------------------
package lfps_pkg;

  localparam int NUM_LANES           = 8;
  localparam int DEFAULT_NUM_SENSORS = 8;
  localparam int LANE_W              = $clog2(NUM_LANES);

  localparam int SAMPLE_W   = 12;
  localparam int LVL_W      = 12;
  localparam int LMAX_W     = 11;
  localparam int RECIP_W    = 24;
  localparam int RECIP_SH   = 24;
  localparam int NPROD_W    = SAMPLE_W + RECIP_W;
  localparam int X1000_W    = 22;
  localparam int QD_W       = LVL_W + LMAX_W;
  localparam int REM_W      = 24;
  localparam int WEIGHT_W   = 6;
  localparam int WPROD_W    = 19;
  localparam int SUM_W      = 22;
  localparam int COUNT_W    = 4;
  localparam int ERR_W      = 18;
  localparam int DERR_W     = 19;
  localparam int PPROD_W    = 35;
  localparam int DPROD_W    = 36;
  localparam int CORR_W     = 37;
  localparam int WHEEL_W    = 39;
  localparam int FRAC_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    CMD_DRIVE = 2'd0,
    CMD_TURN  = 2'd1,
    CMD_HALT  = 2'd2
  } command_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_SPEED     = 3'd0,
    CFG_KP_Q16         = 3'd1,
    CFG_KD_Q16         = 3'd2,
    CFG_HIGH_THRESHOLD = 3'd3,
    CFG_HIGH_COUNT_MIN = 3'd4,
    CFG_TURN_SPEED     = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LANE,
    S_DRAIN1,
    S_DRAIN2,
    S_ERR,
    S_MULP,
    S_MULD,
    S_WHEEL
  } ctrl_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
  } in_item_t;

  typedef struct packed {
    logic [7:0] left_speed;
    logic       left_reverse;
    logic [7:0] right_speed;
    logic       right_reverse;
    command_t   command;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic              issue;
    logic [LANE_W-1:0] lane_idx;
    logic              calc_err;
    logic              mul_p;
    logic              mul_d;
    logic              load;
  } dp_cmd_t;

  typedef struct packed {
    logic halted;
  } dp_status_t;

  typedef struct packed {
    logic [7:0] speed;
    logic       rev;
  } wheel_t;

  function automatic logic [SAMPLE_W-1:0] lane_min(input logic [LANE_W-1:0] idx);
    logic [SAMPLE_W-1:0] v;
    case (idx)
      3'd0:    v = 12'd596;
      3'd1:    v = 12'd527;
      3'd2:    v = 12'd573;
      3'd3:    v = 12'd596;
      3'd4:    v = 12'd550;
      3'd5:    v = 12'd573;
      3'd6:    v = 12'd575;
      3'd7:    v = 12'd667;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  function automatic logic [LMAX_W-1:0] lane_max(input logic [LANE_W-1:0] idx);
    logic [LMAX_W-1:0] v;
    case (idx)
      3'd0:    v = 11'd1802;
      3'd1:    v = 11'd1444;
      3'd2:    v = 11'd1397;
      3'd3:    v = 11'd1113;
      3'd4:    v = 11'd1065;
      3'd5:    v = 11'd1563;
      3'd6:    v = 11'd1224;
      3'd7:    v = 11'd1833;
      default: v = 11'd1;
    endcase
    return v;
  endfunction

  // floor(1000 * 2^24 / lane maximum)
  function automatic logic [RECIP_W-1:0] lane_recip(input logic [LANE_W-1:0] idx);
    logic [RECIP_W-1:0] v;
    case (idx)
      3'd0:    v = 24'd9310330;
      3'd1:    v = 24'd11618570;
      3'd2:    v = 24'd12009460;
      3'd3:    v = 24'd15073868;
      3'd4:    v = 24'd15753254;
      3'd5:    v = 24'd10733983;
      3'd6:    v = 24'd13706875;
      3'd7:    v = 24'd9152872;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] weight_out(input logic [LANE_W-1:0] idx);
    logic signed [WEIGHT_W-1:0] v;
    case (idx)
      3'd0:    v = -6'sd15;
      3'd1:    v = -6'sd10;
      3'd2:    v = -6'sd8;
      3'd3:    v = -6'sd11;
      3'd4:    v = 6'sd14;
      3'd5:    v = 6'sd16;
      3'd6:    v = 6'sd18;
      3'd7:    v = 6'sd20;
      default: v = 6'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] weight_ret(input logic [LANE_W-1:0] idx);
    logic signed [WEIGHT_W-1:0] v;
    case (idx)
      3'd0:    v = -6'sd20;
      3'd1:    v = -6'sd18;
      3'd2:    v = -6'sd16;
      3'd3:    v = -6'sd14;
      3'd4:    v = 6'sd11;
      3'd5:    v = 6'sd8;
      3'd6:    v = 6'sd10;
      3'd7:    v = 6'sd15;
      default: v = 6'sd0;
    endcase
    return v;
  endfunction

  // Q16 wheel value to duty and direction: negative speeds with a non-zero
  // integer part are reversed and scaled by 1.5; duty saturates at 255.
  function automatic wheel_t wheel(input logic signed [WHEEL_W-1:0] q);
    logic [WHEEL_W-1:0]        mag;
    logic [WHEEL_W-FRAC_W-1:0] m;
    logic [WHEEL_W-FRAC_W:0]   m15;
    wheel_t                    w;
    mag = q[WHEEL_W-1] ? WHEEL_W'(-q) : WHEEL_W'(q);
    m   = mag[WHEEL_W-1:FRAC_W];
    if (q[WHEEL_W-1] && (m != '0)) begin
      m15   = {1'b0, m} + {2'b0, m[WHEEL_W-FRAC_W-1:1]};
      w.rev = 1'b1;
    end else begin
      m15   = {1'b0, m};
      w.rev = 1'b0;
    end
    w.speed = (m15 > (WHEEL_W-FRAC_W+1)'(255)) ? 8'd255 : m15[7:0];
    return w;
  endfunction

endpackage

// ===== rtl/core/line_follow_pd_steering.sv =====
// ----------------------------------------------------------------------------
// line_follow_pd_steering
// A new item is taken only once the sequencer is back in idle; the lane
// pipeline takes one lane a cycle, and once halted an item goes straight
// to the wheel stage.
// Reset: synchronous, active high; clears all frame state, loads the default
// configuration and empties the output register.
// ----------------------------------------------------------------------------
module line_follow_pd_steering #(
  parameter int NUM_SENSORS = lfps_pkg::DEFAULT_NUM_SENSORS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lfps_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lfps_pkg::out_item_t             out_data,
  input  logic                            cfg_write,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lfps_pkg::*;

  // The sequencer walks the active lanes through a three-stage normalisation
  // pipeline (offset and reciprocal multiply, remainder correction, weighted
  // accumulate), waits for the pipeline to drain, forms the error and the
  // crossbar decision, then runs the proportional and derivative products one
  // after the other before mapping the correction onto the two wheels.
  //
  // The result sits in an output register. A new item is accepted as soon as
  // the sequencer is back in idle, even while the previous result still waits
  // to be taken; the wheel stage only holds if the register is still full.
  //
  // Once two crossbar events have been seen the block is halted: each item is
  // answered with a halt result straight away and no frame state changes
  // until the next reset.

  dp_cmd_t    cmd;
  dp_status_t status;

  lfps_ctrl #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  lfps_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== rtl/core/lfps_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfps_ctrl
// Sequencer: walks the lanes through the datapath, then steps the error,
// gain multiplications and wheel stage, and owns both handshakes.
// ----------------------------------------------------------------------------
module lfps_ctrl #(
  parameter int NUM_SENSORS = lfps_pkg::DEFAULT_NUM_SENSORS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lfps_pkg::dp_cmd_t    cmd,
  input  lfps_pkg::dp_status_t status
);
  import lfps_pkg::*;

  ctrl_state_t       state, state_next;
  logic [LANE_W-1:0] lane_cnt;
  logic              lane_last;
  logic              out_free;
  logic              accept;

  assign lane_last = (lane_cnt == LANE_W'(NUM_SENSORS - 1));
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = status.halted ? S_WHEEL : S_LANE;
        end
      end
      S_LANE: begin
        if (lane_last) begin
          state_next = S_DRAIN1;
        end
      end
      S_DRAIN1: state_next = S_DRAIN2;
      S_DRAIN2: state_next = S_ERR;
      S_ERR:    state_next = S_MULP;
      S_MULP:   state_next = S_MULD;
      S_MULD:   state_next = S_WHEEL;
      S_WHEEL: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.lane_idx = lane_cnt;
    unique case (state)
      S_IDLE:   cmd.start    = in_valid;
      S_LANE:   cmd.issue    = 1'b1;
      S_ERR:    cmd.calc_err = 1'b1;
      S_MULP:   cmd.mul_p    = 1'b1;
      S_MULD:   cmd.mul_d    = 1'b1;
      S_WHEEL:  cmd.load     = out_free;
      default:  cmd          = cmd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lane_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        lane_cnt <= '0;
      end else if (state == S_LANE) begin
        lane_cnt <= lane_cnt + LANE_W'(1);
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_result_from_wheel: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_WHEEL)
    else $error("result appeared without a wheel stage");

  a_halted_shortcut: assert property (@(posedge clk) disable iff (rst)
    accept && status.halted |=> state == S_WHEEL)
    else $error("halted item did not go straight to the wheel stage");

  a_lane_walk_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_LANE && lane_last |=> state == S_DRAIN1)
    else $error("lane walk did not end after the last lane");
`endif

endmodule

// ===== rtl/core/lfps_datapath.sv =====
// ----------------------------------------------------------------------------
// lfps_datapath
// Lane normalisation pipeline, weighted accumulation, crossbar tracking,
// PD correction and wheel mapping, plus the configuration registers.
// ----------------------------------------------------------------------------
module lfps_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  lfps_pkg::dp_cmd_t                 cmd,
  output lfps_pkg::dp_status_t              status,
  input  lfps_pkg::in_item_t                in_data,
  output lfps_pkg::out_item_t               out_data,
  input  logic                              cfg_write,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lfps_pkg::*;

  // Configuration registers.
  logic [7:0]         base_speed;
  logic [15:0]        kp_q16;
  logic [15:0]        kd_q16;
  logic [11:0]        high_threshold;
  logic [COUNT_W-1:0] high_count_min;
  logic [7:0]         turn_speed;

  // Persistent frame state.
  logic                    prev_frame_high;
  logic                    streak_active;
  logic [1:0]              event_count;
  logic                    return_leg;
  logic signed [ERR_W-1:0] previous_error;
  logic                    halted;

  // Captured frame.
  logic [SAMPLE_W-1:0] samples [NUM_LANES];

  // Stage 1: calibration offset and reciprocal estimate.
  logic [SAMPLE_W-1:0]     sel;
  logic signed [SAMPLE_W:0] adj;
  logic                    adj_pos;
  logic [NPROD_W-1:0]      nprod;
  logic                    s1_valid;
  logic                    s1_pos;
  logic [SAMPLE_W-1:0]     s1_adj;
  logic [LVL_W-1:0]        s1_q0;
  logic [LANE_W-1:0]       s1_lane;

  // Stage 2: remainder correction.
  logic [X1000_W-1:0]      x1000;
  logic [QD_W-1:0]         qd;
  logic signed [REM_W-1:0] rem;
  logic signed [REM_W-1:0] d_ext;
  logic [LVL_W-1:0]        lvl;
  logic                    s2_valid;
  logic                    s2_pos;
  logic [LVL_W-1:0]        s2_lvl;
  logic [LANE_W-1:0]       s2_lane;

  // Stage 3: accumulation.
  logic signed [WEIGHT_W-1:0] w;
  logic signed [WPROD_W-1:0]  wprod;
  logic signed [SUM_W-1:0]    sum;
  logic [COUNT_W-1:0]         count;

  // Error, decision and PD.
  logic signed [SUM_W-1:0]   sum_adj;
  logic                      now_high;
  logic                      xbar_event;
  logic signed [ERR_W-1:0]   err_r;
  logic                      now_high_r;
  logic                      event_r;
  logic                      turn_r;
  logic                      halt_r;
  logic signed [DERR_W-1:0]  derr_r;
  logic signed [PPROD_W-1:0] prod_p;
  logic signed [DPROD_W-1:0] prod_d;
  logic signed [CORR_W-1:0]  corr;
  logic signed [WHEEL_W-1:0] base_q;
  wheel_t                    wl;
  wheel_t                    wr;
  out_item_t                 res;

  assign status.halted = halted;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed     <= 8'd25;
      kp_q16         <= 16'd2327;
      kd_q16         <= 16'd11633;
      high_threshold <= 12'd880;
      high_count_min <= 4'd6;
      turn_speed     <= 8'd100;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BASE_SPEED:     base_speed     <= cfg_data[7:0];
        CFG_KP_Q16:         kp_q16         <= cfg_data[15:0];
        CFG_KD_Q16:         kd_q16         <= cfg_data[15:0];
        CFG_HIGH_THRESHOLD: high_threshold <= cfg_data[11:0];
        CFG_HIGH_COUNT_MIN: high_count_min <= cfg_data[COUNT_W-1:0];
        CFG_TURN_SPEED:     turn_speed     <= cfg_data[7:0];
        default:            base_speed     <= base_speed;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      samples[0] <= in_data.sample_0;
      samples[1] <= in_data.sample_1;
      samples[2] <= in_data.sample_2;
      samples[3] <= in_data.sample_3;
      samples[4] <= in_data.sample_4;
      samples[5] <= in_data.sample_5;
      samples[6] <= in_data.sample_6;
      samples[7] <= in_data.sample_7;
    end
  end

  // Level = adj * 1000 / max. The reciprocal estimate is within one of the
  // true quotient, and the remainder check in stage 2 settles it.
  assign sel     = samples[cmd.lane_idx];
  assign adj     = $signed({1'b0, sel}) - $signed({1'b0, lane_min(cmd.lane_idx)});
  assign adj_pos = !adj[SAMPLE_W] && (adj != '0);
  assign nprod   = NPROD_W'(adj[SAMPLE_W-1:0]) * NPROD_W'(lane_recip(cmd.lane_idx));

  assign x1000 = X1000_W'(s1_adj) * X1000_W'(1000);
  assign qd    = QD_W'(s1_q0) * QD_W'(lane_max(s1_lane));
  assign rem   = $signed({2'b0, x1000}) - $signed({1'b0, qd});
  assign d_ext = $signed(REM_W'(lane_max(s1_lane)));

  always_comb begin
    if (rem < 0) begin
      lvl = s1_q0 - LVL_W'(1);
    end else if (rem >= d_ext) begin
      lvl = s1_q0 + LVL_W'(1);
    end else begin
      lvl = s1_q0;
    end
  end

  assign w     = return_leg ? weight_ret(s2_lane) : weight_out(s2_lane);
  assign wprod = WPROD_W'($signed({1'b0, s2_lvl})) * WPROD_W'(w);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_pos  <= adj_pos;
    s1_adj  <= adj[SAMPLE_W-1:0];
    s1_q0   <= nprod[RECIP_SH +: LVL_W];
    s1_lane <= cmd.lane_idx;
    s2_pos  <= s1_pos;
    s2_lvl  <= lvl;
    s2_lane <= s1_lane;
    if (cmd.start) begin
      sum   <= '0;
      count <= '0;
    end else if (s2_valid && s2_pos) begin
      sum   <= sum + SUM_W'(wprod);
      count <= count + COUNT_W'(s2_lvl > high_threshold);
    end
  end

  // Division by eight toward zero.
  assign sum_adj    = sum + (sum[SUM_W-1] ? SUM_W'(7) : SUM_W'(0));
  assign now_high   = (count >= high_count_min);
  assign xbar_event = now_high && prev_frame_high && !streak_active;

  always_ff @(posedge clk) begin
    if (cmd.calc_err) begin
      err_r      <= ERR_W'(sum_adj >>> 3);
      now_high_r <= now_high;
      event_r    <= xbar_event;
      turn_r     <= xbar_event && (event_count == 2'd0);
      halt_r     <= xbar_event && (event_count == 2'd1);
    end
    if (cmd.mul_p) begin
      prod_p <= PPROD_W'($signed({1'b0, kp_q16})) * PPROD_W'(err_r);
      derr_r <= event_r ? DERR_W'(0) : (DERR_W'(err_r) - DERR_W'(previous_error));
    end
    if (cmd.mul_d) begin
      prod_d <= DPROD_W'($signed({1'b0, kd_q16})) * DPROD_W'(derr_r);
    end
  end

  assign corr   = CORR_W'(prod_p) + CORR_W'(prod_d);
  assign base_q = $signed({(WHEEL_W-8-FRAC_W)'(0), base_speed, FRAC_W'(0)});
  assign wl     = wheel(base_q - WHEEL_W'(corr));
  assign wr     = wheel(base_q + WHEEL_W'(corr));

  always_comb begin
    if (halted || halt_r) begin
      res = '{left_speed: 8'd0, left_reverse: 1'b0, right_speed: 8'd0,
              right_reverse: 1'b0, command: CMD_HALT};
    end else if (turn_r) begin
      res = '{left_speed: turn_speed, left_reverse: 1'b0, right_speed: turn_speed,
              right_reverse: 1'b1, command: CMD_TURN};
    end else begin
      res = '{left_speed: wl.speed, left_reverse: wl.rev, right_speed: wr.speed,
              right_reverse: wr.rev, command: CMD_DRIVE};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_frame_high <= 1'b0;
      streak_active   <= 1'b0;
      event_count     <= 2'd0;
      return_leg      <= 1'b0;
      previous_error  <= '0;
      halted          <= 1'b0;
    end else if (cmd.load && !halted) begin
      if (now_high_r) begin
        if (event_r) begin
          streak_active <= 1'b1;
          event_count   <= event_count + 2'd1;
        end
      end else begin
        streak_active <= 1'b0;
      end
      previous_error <= err_r;
      if (turn_r) begin
        return_leg <= 1'b1;
      end
      if (halt_r) begin
        halted <= 1'b1;
      end
      if (!turn_r && !halt_r) begin
        prev_frame_high <= now_high_r;
      end
    end
  end

`ifndef SYNTHESIS
  a_quotient_estimate: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_pos |-> (rem > -d_ext) && (rem < (d_ext <<< 1)))
    else $error("reciprocal estimate off by more than one");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    event_count != 2'd3)
    else $error("crossbar event count ran past the halt");

  a_halt_state: assert property (@(posedge clk) disable iff (rst)
    halted |-> (event_count == 2'd2) && return_leg)
    else $error("halted without two crossbar events");

  a_halt_output: assert property (@(posedge clk) disable iff (rst)
    cmd.load && halted |=> out_data.command == CMD_HALT)
    else $error("halted block gave a non-halt result");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line-follow PD steering block. Sensor frames
// are sent over a valid/ready channel while the wheel commands are taken with
// random back-pressure. Every accepted frame is run through a behavioural
// model of the normalisation, crossbar detection and PD arithmetic, and each
// wheel command that comes out is compared field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module testbench;
  import lfps_pkg::*;

  // The pipeline is given time to settle after the last command comes out
  // before any register is touched.
  localparam int SETTLE_CYCLES      = 2 * (DEFAULT_NUM_SENSORS + 6);
  localparam int FRAMES_PER_SETTING = 50;
  localparam int ERRORS_SHOWN       = 10;

  // Register indexes that lie beyond the register map; writes to them must
  // leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Percentages of cycles in which the sender holds back and the receiver
  // stalls. They change from one random phase to the next.
  int tx_gap_pct   = 27;
  int rx_stall_pct = 66;
  int fail_count   = 0;

  // Wheel commands predicted for frames that have been accepted but whose
  // command has not yet come out, oldest first.
  out_item_t wheel_cmd_q [$];
  out_item_t wanted_cmd;

  // Model copy of the settings.
  logic [7:0]  base_speed_r;
  logic [15:0] kp_r;
  logic [15:0] kd_r;
  logic [11:0] high_thr_r;
  logic [3:0]  high_min_r;
  logic [7:0]  turn_speed_r;

  // Model copy of the frame-to-frame state.
  logic        crossbar_prev;
  logic        crossbar_streak;
  logic [1:0]  crossbar_events;
  logic        homeward;
  int          last_error;
  logic        stopped;

  line_follow_pd_steering uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Calibration tables and lane access
  // --------------------------------------------------------------------------

  function automatic int lane_floor(input int i);
    case (i)
      0: return 596;
      1: return 527;
      2: return 573;
      3: return 596;
      4: return 550;
      5: return 573;
      6: return 575;
      default: return 667;
    endcase
  endfunction

  function automatic int lane_span(input int i);
    case (i)
      0: return 1802;
      1: return 1444;
      2: return 1397;
      3: return 1113;
      4: return 1065;
      5: return 1563;
      6: return 1224;
      default: return 1833;
    endcase
  endfunction

  // Steering weight of a lane; the return leg uses its own table.
  function automatic int lane_weight(input int i, input logic ret);
    case (i)
      0: return ret ? -20 : -15;
      1: return ret ? -18 : -10;
      2: return ret ? -16 : -8;
      3: return ret ? -14 : -11;
      4: return ret ? 11 : 14;
      5: return ret ? 8 : 16;
      6: return ret ? 10 : 18;
      default: return ret ? 15 : 20;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] get_lane(input in_item_t f, input int i);
    case (i)
      0: return f.sample_0;
      1: return f.sample_1;
      2: return f.sample_2;
      3: return f.sample_3;
      4: return f.sample_4;
      5: return f.sample_5;
      6: return f.sample_6;
      default: return f.sample_7;
    endcase
  endfunction

  function automatic in_item_t set_lane(input in_item_t f, input int i,
                                        input logic [SAMPLE_W-1:0] v);
    in_item_t r;
    r = f;
    case (i)
      0: r.sample_0 = v;
      1: r.sample_1 = v;
      2: r.sample_2 = v;
      3: r.sample_3 = v;
      4: r.sample_4 = v;
      5: r.sample_5 = v;
      6: r.sample_6 = v;
      default: r.sample_7 = v;
    endcase
    return r;
  endfunction

  function automatic in_item_t fill_frame(input logic [SAMPLE_W-1:0] v);
    in_item_t f;
    f = '0;
    for (int i = 0; i < NUM_LANES; i++) f = set_lane(f, i, v);
    return f;
  endfunction

  // --------------------------------------------------------------------------
  // Behavioural model
  // --------------------------------------------------------------------------

  function automatic void load_power_on_state();
    base_speed_r    = 8'd25;
    kp_r            = 16'd2327;
    kd_r            = 16'd11633;
    high_thr_r      = 12'd880;
    high_min_r      = 4'd6;
    turn_speed_r    = 8'd100;
    crossbar_prev   = 1'b0;
    crossbar_streak = 1'b0;
    crossbar_events = 2'd0;
    homeward        = 1'b0;
    last_error      = 0;
    stopped         = 1'b0;
  endfunction

  // Normalised level of one lane: zero at or below the calibration minimum.
  function automatic int lane_level(input in_item_t f, input int i);
    int adj;
    adj = int'(get_lane(f, i)) - lane_floor(i);
    if (adj > 0) return (adj * 1000) / lane_span(i);
    return 0;
  endfunction

  function automatic logic frame_is_high(input in_item_t f);
    int count;
    count = 0;
    for (int i = 0; i < NUM_LANES; i++)
      if (lane_level(f, i) > int'(high_thr_r)) count++;
    return count >= int'(high_min_r);
  endfunction

  // Q16 wheel value to duty and direction. A negative value whose integer
  // part is non-zero is reversed and its magnitude taken one and a half times.
  function automatic void drive_wheel(input longint q, output logic [7:0] spd,
                                      output logic rev);
    longint m;
    rev = 1'b0;
    if (q >= 0) begin
      m = q >>> 16;
    end else begin
      m = (-q) >>> 16;
      if (m > 0) begin
        m   = m + m / 2;
        rev = 1'b1;
      end
    end
    spd = (m > 255) ? 8'd255 : m[7:0];
  endfunction

  // Works out the wheel command for one accepted frame and advances the
  // model state exactly as the block does.
  function automatic out_item_t compute_wheel_cmd(input in_item_t f);
    out_item_t  r;
    int         sum;
    int         err;
    int         derr;
    logic       now_high;
    longint     corr;
    longint     base_q;
    logic [7:0] ls;
    logic [7:0] rs;
    logic       lr;
    logic       rr;
    r         = '0;
    r.command = CMD_HALT;
    if (stopped) return r;

    sum = 0;
    for (int i = 0; i < NUM_LANES; i++) sum += lane_level(f, i) * lane_weight(i, homeward);
    err      = sum / 8;
    now_high = frame_is_high(f);

    if (now_high) begin
      if (crossbar_prev && !crossbar_streak) begin
        crossbar_streak = 1'b1;
        crossbar_events = crossbar_events + 2'd1;
        last_error      = err;
        if (crossbar_events == 2'd1) begin
          homeward        = 1'b1;
          r.left_speed    = turn_speed_r;
          r.left_reverse  = 1'b0;
          r.right_speed   = turn_speed_r;
          r.right_reverse = 1'b1;
          r.command       = CMD_TURN;
          return r;
        end else if (crossbar_events == 2'd2) begin
          stopped = 1'b1;
          return r;
        end
      end
    end else begin
      crossbar_streak = 1'b0;
    end
    crossbar_prev = now_high;

    derr       = err - last_error;
    last_error = err;
    corr       = longint'(kp_r) * longint'(err) + longint'(kd_r) * longint'(derr);
    base_q     = longint'(base_speed_r) * 65536;
    drive_wheel(base_q - corr, ls, lr);
    drive_wheel(base_q + corr, rs, rr);
    r.left_speed    = ls;
    r.left_reverse  = lr;
    r.right_speed   = rs;
    r.right_reverse = rr;
    r.command       = CMD_DRIVE;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= ERRORS_SHOWN) $display("%s", msg);
  endtask

  // Offers one frame, possibly after a few idle cycles, and records its
  // predicted command once the block has taken it. Always entered and left
  // just after a rising edge.
  task automatic send_frame(input in_item_t f);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_ready !== 1'b1);
    wheel_cmd_q.push_back(compute_wheel_cmd(f));
  endtask

  // Stops sending and waits until every predicted command has come out and
  // the pipeline has had time to go quiet.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (wheel_cmd_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_BASE_SPEED:     base_speed_r = value[7:0];
      CFG_KP_Q16:         kp_r         = value[15:0];
      CFG_KD_Q16:         kd_r         = value[15:0];
      CFG_HIGH_THRESHOLD: high_thr_r   = value[11:0];
      CFG_HIGH_COUNT_MIN: high_min_r   = value[3:0];
      CFG_TURN_SPEED:     turn_speed_r = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Random register value with the two ends of the range picked often.
  function automatic int pick_value(input int maxv);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return maxv;
    return $urandom_range(0, maxv);
  endfunction

  // The high-lane minimum never goes to zero here: with zero every frame is
  // high and a crossbar event could not be kept out of the random phases.
  task automatic shuffle_settings();
    write_reg(CFG_BASE_SPEED, pick_value(255));
    write_reg(CFG_KP_Q16, pick_value(65535));
    write_reg(CFG_KD_Q16, pick_value(65535));
    write_reg(CFG_HIGH_THRESHOLD, pick_value(4095));
    write_reg(CFG_HIGH_COUNT_MIN,
              ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8));
    write_reg(CFG_TURN_SPEED, pick_value(255));
  endtask

  // Frames shaped like what the sensor bar sees: a line under a few lanes,
  // a crossbar under all of them, raw noise, or bare floor.
  function automatic in_item_t random_frame();
    in_item_t f;
    int       mode;
    int       centre;
    int       v;
    f      = '0;
    mode   = $urandom_range(0, 99);
    centre = $urandom_range(0, NUM_LANES - 1);
    for (int i = 0; i < NUM_LANES; i++) begin
      if (mode < 40) begin
        if (i >= centre - 1 && i <= centre + 1) v = lane_floor(i) + $urandom_range(100, 1800);
        else v = $urandom_range(0, lane_floor(i) + 150);
      end else if (mode < 65) begin
        v = $urandom_range(2000, 4095);
      end else if (mode < 85) begin
        v = $urandom_range(0, 4095);
      end else begin
        v = $urandom_range(0, 700);
      end
      if (v > 4095) v = 4095;
      f = set_lane(f, i, v[SAMPLE_W-1:0]);
    end
    return f;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Power-on settings: blank floor, a centred line, and every lane exactly at
  // and one count above its calibration minimum.
  task automatic test_reset_defaults();
    in_item_t f;
    send_frame(fill_frame('0));
    f = set_lane(fill_frame('0), 3, 12'd1500);
    send_frame(set_lane(f, 4, 12'd1500));
    f = '0;
    for (int i = 0; i < NUM_LANES; i++) f = set_lane(f, i, SAMPLE_W'(lane_floor(i)));
    send_frame(f);
    for (int i = 0; i < NUM_LANES; i++) f = set_lane(f, i, SAMPLE_W'(lane_floor(i) + 1));
    send_frame(f);
  endtask

  // Sample extremes and alternating bit patterns, with a high-lane minimum
  // above eight so that no frame can count as a crossbar.
  task automatic test_sample_extremes();
    wait_for_drain();
    write_reg(CFG_HIGH_COUNT_MIN, 9);
    send_frame(fill_frame('1));
    send_frame(fill_frame(12'hAAA));
    wait_for_drain();
    write_reg(CFG_HIGH_COUNT_MIN, 15);
    send_frame(fill_frame(12'h555));
    send_frame(set_lane(fill_frame('0), 0, '1));
    send_frame(set_lane(fill_frame('0), NUM_LANES - 1, '1));
  endtask

  // Gains and speeds at their ends: hard saturation both ways, writes to
  // unmapped indexes, all-zero gains, and a small negative value that must
  // truncate to a forward zero.
  task automatic test_gain_extremes();
    wait_for_drain();
    write_reg(CFG_BASE_SPEED, 255);
    write_reg(CFG_KP_Q16, 65535);
    write_reg(CFG_KD_Q16, 65535);
    write_reg(CFG_HIGH_THRESHOLD, 4095);
    send_frame(set_lane(fill_frame('0), 0, '1));
    send_frame(set_lane(fill_frame('0), NUM_LANES - 1, '1));
    send_frame(fill_frame('0));
    wait_for_drain();
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 0);
    send_frame(set_lane(fill_frame('0), NUM_LANES - 1, '1));
    wait_for_drain();
    write_reg(CFG_BASE_SPEED, 0);
    write_reg(CFG_KP_Q16, 0);
    write_reg(CFG_KD_Q16, 0);
    write_reg(CFG_HIGH_THRESHOLD, 0);
    send_frame(fill_frame('1));
    wait_for_drain();
    write_reg(CFG_KP_Q16, 1);
    send_frame(set_lane(fill_frame('0), 4, SAMPLE_W'(lane_floor(4) + 200)));
  endtask

  // First crossbar event. A minimum of zero makes even a blank frame high:
  // the first such frame arms the detector, the second commands the turn,
  // the third falls inside the same streak and steers on the return table.
  task automatic test_turn_around();
    wait_for_drain();
    write_reg(CFG_HIGH_COUNT_MIN, 9);
    send_frame(fill_frame(12'd2000));
    wait_for_drain();
    write_reg(CFG_HIGH_COUNT_MIN, 0);
    write_reg(CFG_TURN_SPEED, 255);
    repeat (3) send_frame(fill_frame('0));
    wait_for_drain();
    write_reg(CFG_HIGH_COUNT_MIN, 6);
    send_frame(fill_frame('0));
    wait_for_drain();
    write_reg(CFG_TURN_SPEED, 0);
  endtask

  // Random frames in chunks, each chunk under fresh settings. A frame that
  // would complete a crossbar event is replaced by a blank one, so the
  // block neither turns nor halts before the directed tests ask for it.
  task automatic run_random_phase(input int gap_pct, input int stall_pct,
                                  input int n_frames);
    in_item_t f;
    tx_gap_pct   = gap_pct;
    rx_stall_pct = stall_pct;
    for (int k = 0; k < n_frames; k++) begin
      if (k % FRAMES_PER_SETTING == 0) begin
        wait_for_drain();
        shuffle_settings();
      end
      f = random_frame();
      if (!stopped && crossbar_prev && !crossbar_streak && frame_is_high(f)) f = '0;
      send_frame(f);
    end
  endtask

  // Second crossbar event halts the block; from then on every frame,
  // whatever it holds and whatever the settings, gives the halt command.
  task automatic test_halt();
    wait_for_drain();
    write_reg(CFG_HIGH_COUNT_MIN, 6);
    write_reg(CFG_HIGH_THRESHOLD, 880);
    send_frame(fill_frame('0));
    send_frame(fill_frame('1));
    send_frame(fill_frame('1));
    repeat (8) send_frame(random_frame());
    wait_for_drain();
    write_reg(CFG_BASE_SPEED, 200);
    send_frame(fill_frame('1));
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (wheel_cmd_q.size() == 0) begin
        flag_error($sformatf("unexpected wheel command: L %0d rev %0b R %0d rev %0b cmd %0d",
                             out_data.left_speed, out_data.left_reverse,
                             out_data.right_speed, out_data.right_reverse,
                             out_data.command));
      end else begin
        wanted_cmd = wheel_cmd_q.pop_front();
        if (out_data.left_speed !== wanted_cmd.left_speed ||
            out_data.left_reverse !== wanted_cmd.left_reverse ||
            out_data.right_speed !== wanted_cmd.right_speed ||
            out_data.right_reverse !== wanted_cmd.right_reverse ||
            out_data.command !== wanted_cmd.command) begin
          flag_error($sformatf({"wheel command mismatch: expected L %0d rev %0b R %0d rev %0b",
                                " cmd %0d, got L %0d rev %0b R %0d rev %0b cmd %0d"},
                               wanted_cmd.left_speed, wanted_cmd.left_reverse,
                               wanted_cmd.right_speed, wanted_cmd.right_reverse,
                               wanted_cmd.command,
                               out_data.left_speed, out_data.left_reverse,
                               out_data.right_speed, out_data.right_reverse,
                               out_data.command));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin
    load_power_on_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_sample_extremes();
    test_gain_extremes();
    run_random_phase(27, 66, 250);
    test_turn_around();
    run_random_phase(66, 27, 250);
    run_random_phase(0, 0, 250);
    test_halt();

    wait_for_drain();
    if (fail_count == 0 && wheel_cmd_q.size() == 0) begin
      $display("PASS line_follow_pd_steering");
    end else begin
      $display("FAIL line_follow_pd_steering");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #(2_000_000);
    $display("FAIL line_follow_pd_steering");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lfps_pkg.sv
rtl/core/lfps_ctrl.sv
rtl/core/lfps_datapath.sv
rtl/core/line_follow_pd_steering.sv
sim/testbench.sv
